// ----- hdl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache core.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int unsigned FIELD_BITS = 64;
	localparam int unsigned CAP_BITS   = 5;
	localparam int unsigned CAP_RESET  = 16;
	localparam int unsigned APB_BITS   = 32;
	localparam int unsigned ADDR_BITS  = 3;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_STORE  = 1'b1;

	// register word index
	localparam logic REG_CAPACITY_USED = 1'b0;

	typedef struct packed {
		logic                  func;
		logic [FIELD_BITS-1:0] key;
		logic [FIELD_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [FIELD_BITS-1:0] read_value;
	} rsp_t;

	// control from the sequencer to the compare unit
	typedef struct packed {
		logic clr;        // start a new scan
		logic scan;       // an entry word is present for the scan
		logic limit_all;  // age every valid entry during the sweep
	} unit_ctl_t;

endpackage

// ----- hdl/lru_key_value_cache_core.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One item (lookup or store) is taken while busy is low and start is high.
// The core then scans all ENTRIES slots through a single memory read port,
// one slot a cycle, and for every item that changes recency it sweeps the
// slots a second time to rewrite their ages. An item that changes state
// (any hit, or a store) goes through scan, decide, sweep and result; a
// lookup that misses skips the sweep. The result appears on rsp for
// exactly one cycle with done high and must be taken then: the receiver
// cannot stall it. busy is high from acceptance up to and including the
// done cycle. Valid flags clear at reset, so no clearing pass is needed.
// Write capacity_used over APB only while idle; the core does not check.
module lru_key_value_cache_core #(
	parameter int unsigned ENTRIES    = 16,
	parameter int unsigned KEY_BITS   = 64,
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  lkv_pkg::req_t                     req,
	output logic                              done,
	output lkv_pkg::rsp_t                     rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lkv_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [lkv_pkg::APB_BITS-1:0]      pwdata,
	output logic [lkv_pkg::APB_BITS-1:0]      prdata,
	output logic                              pready
);

	localparam int unsigned AW   = $clog2(ENTRIES);
	localparam int unsigned CW   = $clog2(ENTRIES + 1);
	localparam int unsigned CMPW = (CW > lkv_pkg::CAP_BITS) ? CW : lkv_pkg::CAP_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_RESP   = 3'd4;

	logic [2:0]                      state_q;
	logic [CW-1:0]                   cnt_q;
	logic [lkv_pkg::CAP_BITS-1:0]    cap_q;
	logic [CW-1:0]                   occ_q;
	logic                            func_q;
	logic [KEY_BITS-1:0]             key_q;
	logic [VALUE_BITS-1:0]           val_q;
	logic [AW-1:0]                   tgt_q;
	logic [AW-1:0]                   limit_q;
	logic                            limit_all_q;
	logic                            rsp_hit_q;
	logic [lkv_pkg::FIELD_BITS-1:0]  rsp_val_q;
	logic                            elem_s1;
	logic [AW-1:0]                   idx_s1;

	logic                            accept;
	logic                            cfg_wr;
	logic                            last;
	logic                            full;
	logic [CMPW-1:0]                 occ_ext;
	logic [CMPW-1:0]                 cap_ext;

	logic                            rd_en;
	logic [AW-1:0]                   rd_idx;
	logic                            valid_s1;
	logic [KEY_BITS-1:0]             ekey_s1;
	logic [VALUE_BITS-1:0]           edata_s1;
	logic [AW-1:0]                   eage_s1;

	logic                            kd_we;
	logic [AW-1:0]                   kd_idx;
	logic                            valid_set;

	lkv_pkg::unit_ctl_t              ctl;
	logic                            hit;
	logic [AW-1:0]                   hit_idx;
	logic [AW-1:0]                   hit_age;
	logic                            any;
	logic [AW-1:0]                   victim;
	logic [AW-1:0]                   oldest;
	logic                            free;
	logic [AW-1:0]                   free_idx;
	logic [AW-1:0]                   aged;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_BITS'(lkv_pkg::CAP_RESET);
		end else if (cfg_wr && paddr[2] == lkv_pkg::REG_CAPACITY_USED) begin
			cap_q <= pwdata[lkv_pkg::CAP_BITS-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == lkv_pkg::REG_CAPACITY_USED) begin
			prdata = lkv_pkg::APB_BITS'(cap_q);
		end else begin
			prdata = '0;
		end
	end

	// ------------------------------------------------------------------
	// Capacity check: zero counts as one, anything above ENTRIES saturates,
	// so a cache holding all ENTRIES slots is always full.
	// ------------------------------------------------------------------
	assign occ_ext = CMPW'(occ_q);
	assign cap_ext = CMPW'(cap_q);
	assign full    = (cap_q == '0) ? (occ_q != '0) :
	                 ((occ_ext >= cap_ext) || (occ_q == CW'(ENTRIES)));

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign last   = (cnt_q == CW'(ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			occ_q       <= '0;
			elem_s1     <= 1'b0;
			limit_all_q <= 1'b0;
		end else begin
			elem_s1 <= (state_q == ST_SCAN || state_q == ST_UPDATE) && !last;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// the final entry word is consumed at the edge that leaves
					if (last) begin
						state_q <= ST_DECIDE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (hit) begin
						limit_all_q <= 1'b0;
						state_q     <= ST_UPDATE;
					end else if (func_q == lkv_pkg::FUNC_LOOKUP) begin
						state_q <= ST_RESP;
					end else if (full && any) begin
						limit_all_q <= 1'b0;
						state_q     <= ST_UPDATE;
					end else if (free) begin
						limit_all_q <= 1'b1;
						occ_q       <= occ_q + CW'(1);
						state_q     <= ST_UPDATE;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_UPDATE: begin
					if (last) begin
						state_q <= ST_RESP;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the item and pick the slot to promote; payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= req.func;
			key_q     <= req.key[KEY_BITS-1:0];
			val_q     <= req.value[VALUE_BITS-1:0];
			rsp_val_q <= '0;
		end
		if (state_q == ST_DECIDE) begin
			rsp_hit_q <= hit;
			if (hit) begin
				tgt_q   <= hit_idx;
				limit_q <= hit_age;
			end else if (full && any) begin
				tgt_q   <= victim;
				limit_q <= oldest;
			end else begin
				tgt_q   <= free_idx;
				limit_q <= '0;
			end
		end
		// the hit entry's data arrives in the first sweep cycle
		if (state_q == ST_UPDATE && cnt_q == '0 && rsp_hit_q &&
		    func_q == lkv_pkg::FUNC_LOOKUP) begin
			rsp_val_q <= lkv_pkg::FIELD_BITS'(edata_s1);
		end
		if (rd_en) begin
			idx_s1 <= rd_idx;
		end
	end

	// ------------------------------------------------------------------
	// Entry memory access
	// ------------------------------------------------------------------
	always_comb begin
		rd_en  = 1'b0;
		rd_idx = cnt_q[AW-1:0];
		if ((state_q == ST_SCAN || state_q == ST_UPDATE) && !last) begin
			rd_en = 1'b1;
		end else if (state_q == ST_DECIDE) begin
			rd_en  = 1'b1;
			rd_idx = hit_idx;
		end
	end

	// Write key and data for a store hit, an eviction or an insert.
	always_comb begin
		kd_we     = 1'b0;
		valid_set = 1'b0;
		kd_idx    = hit_idx;
		if (state_q == ST_DECIDE && func_q == lkv_pkg::FUNC_STORE) begin
			if (hit) begin
				kd_we = 1'b1;
			end else if (full && any) begin
				kd_we  = 1'b1;
				kd_idx = victim;
			end else if (free) begin
				kd_we     = 1'b1;
				valid_set = 1'b1;
				kd_idx    = free_idx;
			end
		end
	end

	lkv_entry_store #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_idx    (rd_idx),
		.valid_s1  (valid_s1),
		.key_s1    (ekey_s1),
		.data_s1   (edata_s1),
		.age_s1    (eage_s1),
		.kd_we     (kd_we),
		.kd_idx    (kd_idx),
		.kd_key    (key_q),
		.kd_data   (val_q),
		.valid_set (valid_set),
		.age_we    (elem_s1 && state_q == ST_UPDATE),
		.age_idx   (idx_s1),
		.age_data  (aged)
	);

	// ------------------------------------------------------------------
	// Shared compare unit
	// ------------------------------------------------------------------
	assign ctl.clr       = accept;
	assign ctl.scan      = elem_s1 && state_q == ST_SCAN;
	assign ctl.limit_all = limit_all_q;

	lkv_scan_unit #(
		.KEY_BITS (KEY_BITS),
		.AW       (AW)
	) u_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.key        (key_q),
		.e_valid    (valid_s1),
		.e_key      (ekey_s1),
		.e_age      (eage_s1),
		.e_idx      (idx_s1),
		.tgt_idx    (tgt_q),
		.limit      (limit_q),
		.hit_q      (hit),
		.hit_idx_q  (hit_idx),
		.hit_age_q  (hit_age),
		.any_q      (any),
		.victim_q   (victim),
		.oldest_q   (oldest),
		.free_q     (free),
		.free_idx_q (free_idx),
		.aged       (aged)
	);

	// ------------------------------------------------------------------
	// Result
	// ------------------------------------------------------------------
	assign done           = (state_q == ST_RESP);
	assign rsp.hit        = rsp_hit_q;
	assign rsp.read_value = rsp_val_q;

endmodule

// ----- hdl/lkv_entry_store.sv -----
// ----------------------------------------------------------------------------
// lkv_entry_store
// Entry memories (key, data, age) with one registered read port, plus the
// per-entry valid flags.
// ----------------------------------------------------------------------------
module lkv_entry_store #(
	parameter int unsigned ENTRIES    = 16,
	parameter int unsigned KEY_BITS   = 64,
	parameter int unsigned VALUE_BITS = 64,
	parameter int unsigned AW         = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_idx,
	output logic                  valid_s1,
	output logic [KEY_BITS-1:0]   key_s1,
	output logic [VALUE_BITS-1:0] data_s1,
	output logic [AW-1:0]         age_s1,
	input  logic                  kd_we,
	input  logic [AW-1:0]         kd_idx,
	input  logic [KEY_BITS-1:0]   kd_key,
	input  logic [VALUE_BITS-1:0] kd_data,
	input  logic                  valid_set,
	input  logic                  age_we,
	input  logic [AW-1:0]         age_idx,
	input  logic [AW-1:0]         age_data
);

	logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
	logic [VALUE_BITS-1:0] data_mem [ENTRIES];
	logic [AW-1:0]         age_mem  [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (valid_set) begin
			valid_q[kd_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (kd_we) begin
			key_mem[kd_idx]  <= kd_key;
			data_mem[kd_idx] <= kd_data;
		end
		if (age_we) begin
			age_mem[age_idx] <= age_data;
		end
		if (rd_en) begin
			valid_s1 <= valid_q[rd_idx];
			key_s1   <= key_mem[rd_idx];
			data_s1  <= data_mem[rd_idx];
			age_s1   <= age_mem[rd_idx];
		end
	end

endmodule

// ----- hdl/lkv_scan_unit.sv -----
// ----------------------------------------------------------------------------
// lkv_scan_unit
// Shared compare unit: matches one entry word per cycle against the key,
// tracks the oldest valid and first free entry, and forms the aged value
// written back during the recency sweep.
// ----------------------------------------------------------------------------
module lkv_scan_unit #(
	parameter int unsigned KEY_BITS = 64,
	parameter int unsigned AW       = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lkv_pkg::unit_ctl_t  ctl,
	input  logic [KEY_BITS-1:0] key,
	input  logic                e_valid,
	input  logic [KEY_BITS-1:0] e_key,
	input  logic [AW-1:0]       e_age,
	input  logic [AW-1:0]       e_idx,
	input  logic [AW-1:0]       tgt_idx,
	input  logic [AW-1:0]       limit,
	output logic                hit_q,
	output logic [AW-1:0]       hit_idx_q,
	output logic [AW-1:0]       hit_age_q,
	output logic                any_q,
	output logic [AW-1:0]       victim_q,
	output logic [AW-1:0]       oldest_q,
	output logic                free_q,
	output logic [AW-1:0]       free_idx_q,
	output logic [AW-1:0]       aged
);

	logic younger;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_age_q  <= '0;
			any_q      <= 1'b0;
			victim_q   <= '0;
			oldest_q   <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
		end else if (ctl.clr) begin
			hit_q  <= 1'b0;
			any_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.scan) begin
			if (e_valid) begin
				// keep the first match only
				if (!hit_q && e_key == key) begin
					hit_q     <= 1'b1;
					hit_idx_q <= e_idx;
					hit_age_q <= e_age;
				end
				if (!any_q || e_age > oldest_q) begin
					any_q    <= 1'b1;
					victim_q <= e_idx;
					oldest_q <= e_age;
				end
			end else if (!free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= e_idx;
			end
		end
	end

	// age every valid entry younger than the promoted one, or every valid entry on an insert
	assign younger = e_valid && (ctl.limit_all || e_age < limit);

	always_comb begin
		if (e_idx == tgt_idx) begin
			aged = '0;
		end else if (younger) begin
			aged = e_age + AW'(1);
		end else begin
			aged = e_age;
		end
	end

endmodule
